/* hw/rtl/ready_queue_scheduler_macros.svh */
// assertion helpers for the scheduler datapath
`ifndef READY_QUEUE_SCHEDULER_MACROS_SVH
`define READY_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, off while reset is held
`define RQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define RQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rqs_pkg.sv */
`default_nettype none

package rqs_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 8;
  localparam int CDATA_W = 16;

  localparam logic [0:0] OP_ADD = 1'b0;
  localparam logic [0:0] OP_RUN = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RUNNING = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_MODE    = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_QUANTUM = 8'd1;

  localparam logic [BURST_W-1:0] QUANTUM_RST = 16'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW,
    WR_KEEP
  } wr_sel_t;

  typedef enum logic [1:0] {
    EMIT_ADDED,
    EMIT_FULL,
    EMIT_EMPTY,
    EMIT_ENTRY
  } emit_sel_t;

  typedef struct packed {
    logic      in_ready;
    logic      idx_clr;
    logic      idx_inc;
    logic      idx_dec;
    logic      idx_load_cnt;
    logic      rd;
    logic      rd_prev;
    logic      wr;
    wr_sel_t   wr_sel;
    logic      pos_load_idx;
    logic      pos_load_cnt;
    logic      keep_clr;
    logic      keep_inc;
    logic      cnt_inc;
    logic      cnt_load_keep;
    logic      emit;
    emit_sel_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic              op;
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              cnt_zero;
    logic              idx_at_cnt;
    logic              idx_gt_pos;
    logic              idx_last;
    logic              hit;
    logic              survive;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/rqs_in_if.sv */
`default_nettype none

interface rqs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [rqs_pkg::ID_W-1:0]    proc_id;
  logic [rqs_pkg::BURST_W-1:0] burst;
  logic [rqs_pkg::PRIO_W-1:0]  prio;

  modport source (output valid, op, proc_id, burst, prio, input ready);
  modport sink (input valid, op, proc_id, burst, prio, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rqs_out_if.sv */
`default_nettype none

interface rqs_out_if;
  logic                        valid;
  logic                        ready;
  logic [rqs_pkg::KIND_W-1:0]  kind;
  logic [rqs_pkg::ID_W-1:0]    out_id;
  logic [rqs_pkg::BURST_W-1:0] out_burst;
  logic [rqs_pkg::PRIO_W-1:0]  out_prio;
  logic                        last;

  modport source (output valid, kind, out_id, out_burst, out_prio, last, input ready);
  modport sink (input valid, kind, out_id, out_burst, out_prio, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rqs_cfg_if.sv */
`default_nettype none

interface rqs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rqs_pkg::CIDX_W-1:0]  index;
  logic [rqs_pkg::CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rqs_ctrl.sv */
`default_nettype none

module rqs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rqs_pkg::sts_t sts,
  output rqs_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_START,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WR_NEW,
    S_RR_RD,
    S_RR_CHK,
    S_LIST_START,
    S_LIST_RD,
    S_LIST_EMIT,
    S_DONE_ADD,
    S_DONE_FULL,
    S_DONE_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.idx_clr = 1'b1;
        if (sts.op == rqs_pkg::OP_ADD) begin
          if (sts.full) begin
            state_nxt = S_DONE_FULL;
          end else begin
            cmd.pos_load_cnt = 1'b1;
            if (sts.mode inside {rqs_pkg::MODE_SJF, rqs_pkg::MODE_PRIO}) begin
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_WR_NEW;
            end
          end
        end else begin
          cmd.keep_clr = 1'b1;
          if (sts.mode == rqs_pkg::MODE_RR) begin
            state_nxt = S_RR_RD;
          end else begin
            state_nxt = S_LIST_START;
          end
        end
      end
      // find the first queued entry the new one goes ahead of
      S_SCAN_RD: begin
        if (sts.idx_at_cnt) begin
          state_nxt = S_SHIFT_START;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.hit) begin
          cmd.pos_load_idx = 1'b1;
          state_nxt        = S_SHIFT_START;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SHIFT_START: begin
        cmd.idx_load_cnt = 1'b1;
        state_nxt        = S_SHIFT_RD;
      end
      // move the tail down one place, last entry first
      S_SHIFT_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd      = 1'b1;
          cmd.rd_prev = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end else begin
          state_nxt = S_WR_NEW;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr      = 1'b1;
        cmd.wr_sel  = rqs_pkg::WR_SHIFT;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_SHIFT_RD;
      end
      S_WR_NEW: begin
        cmd.wr      = 1'b1;
        cmd.wr_sel  = rqs_pkg::WR_NEW;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE_ADD;
      end
      // round robin pass compacts survivors toward the head
      S_RR_RD: begin
        if (sts.idx_at_cnt) begin
          cmd.cnt_load_keep = 1'b1;
          state_nxt         = S_LIST_START;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_RR_CHK;
        end
      end
      S_RR_CHK: begin
        if (sts.survive) begin
          cmd.wr       = 1'b1;
          cmd.wr_sel   = rqs_pkg::WR_KEEP;
          cmd.keep_inc = 1'b1;
        end
        cmd.idx_inc = 1'b1;
        state_nxt   = S_RR_RD;
      end
      S_LIST_START: begin
        cmd.idx_clr = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = S_DONE_EMPTY;
        end else begin
          state_nxt = S_LIST_RD;
        end
      end
      S_LIST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rqs_pkg::EMIT_ENTRY;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_LIST_RD;
          end
        end
      end
      S_DONE_ADD: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rqs_pkg::EMIT_ADDED;
          state_nxt    = S_IDLE;
        end
      end
      S_DONE_FULL: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rqs_pkg::EMIT_FULL;
          state_nxt    = S_IDLE;
        end
      end
      S_DONE_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = rqs_pkg::EMIT_EMPTY;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/rqs_dp.sv */
`default_nettype none

`include "ready_queue_scheduler_macros.svh"

module rqs_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rqs_in_if.sink             in_ch,
  rqs_out_if.source          out_ch,
  rqs_cfg_if.sink            cfg_ch,
  input  wire rqs_pkg::cmd_t cmd,
  output rqs_pkg::sts_t      sts
);

  rqs_pkg::entry_t mem [rqs_pkg::DEPTH];

  logic [rqs_pkg::MODE_W-1:0]  mode_r;
  logic [rqs_pkg::BURST_W-1:0] quantum_r;
  logic                        op_r;
  rqs_pkg::entry_t             item_r;
  rqs_pkg::entry_t             rdata_r;
  logic [rqs_pkg::CW-1:0]      cnt_r;
  logic [rqs_pkg::CW-1:0]      idx_r;
  logic [rqs_pkg::CW-1:0]      pos_r;
  logic [rqs_pkg::CW-1:0]      keep_r;

  logic                        out_valid_r;
  logic [rqs_pkg::KIND_W-1:0]  kind_r;
  rqs_pkg::entry_t             odata_r;
  logic                        last_r;
  logic [rqs_pkg::KIND_W-1:0]  kind_nxt;
  rqs_pkg::entry_t             odata_nxt;
  logic                        last_nxt;

  logic [rqs_pkg::CW-1:0]      idx_prev;
  logic [rqs_pkg::CW-1:0]      idx_next;
  logic [rqs_pkg::AW-1:0]      rd_addr;
  logic [rqs_pkg::AW-1:0]      wr_addr;
  rqs_pkg::entry_t             wr_data;
  logic                        out_free;

  assign idx_prev = idx_r - 1'b1;
  assign idx_next = idx_r + 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= rqs_pkg::MODE_FCFS;
      quantum_r <= rqs_pkg::QUANTUM_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == rqs_pkg::CFG_MODE) begin
        mode_r <= cfg_ch.data[rqs_pkg::MODE_W-1:0];
      end else if (cfg_ch.index == rqs_pkg::CFG_QUANTUM) begin
        quantum_r <= cfg_ch.data[rqs_pkg::BURST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_ready) begin
      op_r         <= in_ch.op;
      item_r.id    <= in_ch.proc_id;
      item_r.burst <= in_ch.burst;
      item_r.prio  <= in_ch.prio;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.cnt_load_keep) begin
      cnt_r <= keep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pos_r  <= '0;
      keep_r <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_load_cnt) begin
        idx_r <= cnt_r;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_next;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_prev;
      end
      if (cmd.pos_load_cnt) begin
        pos_r <= cnt_r;
      end else if (cmd.pos_load_idx) begin
        pos_r <= idx_r;
      end
      if (cmd.keep_clr) begin
        keep_r <= '0;
      end else if (cmd.keep_inc) begin
        keep_r <= keep_r + 1'b1;
      end
    end
  end

  // entry memory, one write and one registered read per cycle
  assign rd_addr = cmd.rd_prev ? idx_prev[rqs_pkg::AW-1:0] : idx_r[rqs_pkg::AW-1:0];

  always_comb begin
    wr_addr = idx_r[rqs_pkg::AW-1:0];
    wr_data = rdata_r;
    case (cmd.wr_sel)
      rqs_pkg::WR_SHIFT: begin
        wr_addr = idx_r[rqs_pkg::AW-1:0];
        wr_data = rdata_r;
      end
      rqs_pkg::WR_NEW: begin
        wr_addr = pos_r[rqs_pkg::AW-1:0];
        wr_data = item_r;
      end
      rqs_pkg::WR_KEEP: begin
        wr_addr       = keep_r[rqs_pkg::AW-1:0];
        wr_data       = rdata_r;
        wr_data.burst = rdata_r.burst - quantum_r;
      end
      default: begin
        wr_addr = idx_r[rqs_pkg::AW-1:0];
        wr_data = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    kind_nxt  = rqs_pkg::KIND_EMPTY;
    odata_nxt = '0;
    last_nxt  = 1'b1;
    case (cmd.emit_sel)
      rqs_pkg::EMIT_ADDED: kind_nxt = rqs_pkg::KIND_ADDED;
      rqs_pkg::EMIT_FULL:  kind_nxt = rqs_pkg::KIND_FULL;
      rqs_pkg::EMIT_EMPTY: kind_nxt = rqs_pkg::KIND_EMPTY;
      rqs_pkg::EMIT_ENTRY: begin
        kind_nxt  = (idx_r == '0) ? rqs_pkg::KIND_RUNNING : rqs_pkg::KIND_READY;
        odata_nxt = rdata_r;
        last_nxt  = sts.idx_last;
      end
      default: kind_nxt = rqs_pkg::KIND_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r  <= kind_nxt;
      odata_r <= odata_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.out_id    = odata_r.id;
  assign out_ch.out_burst = odata_r.burst;
  assign out_ch.out_prio  = odata_r.prio;
  assign out_ch.last      = last_r;

  // status toward the controller
  always_comb begin
    sts.in_valid   = in_ch.valid;
    sts.op         = op_r;
    sts.mode       = mode_r;
    sts.full       = (cnt_r == rqs_pkg::DEPTH_C);
    sts.cnt_zero   = (cnt_r == '0);
    sts.idx_at_cnt = (idx_r == cnt_r);
    sts.idx_gt_pos = (idx_r > pos_r);
    sts.idx_last   = (idx_next == cnt_r);
    sts.survive    = (rdata_r.burst > quantum_r);
    case (mode_r)
      rqs_pkg::MODE_SJF:  sts.hit = (rdata_r.burst > item_r.burst);
      rqs_pkg::MODE_PRIO: sts.hit = (rdata_r.prio < item_r.prio);
      default:            sts.hit = 1'b0;
    endcase
    sts.out_free = out_free;
  end

  `RQS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= rqs_pkg::DEPTH_C, "queue count past depth")
  `RQS_ASSERT_IMP(a_emit_free, cmd.emit, out_free, "result overwrites a pending beat")
  `RQS_ASSERT_NXT(a_cnt_step, cmd.cnt_inc, cnt_r == $past(cnt_r) + 1'b1, "count step lost")

endmodule

`default_nettype wire

/* hw/rtl/ready_queue_scheduler.sv */
// channel   role     beat content
// in_ch     sink     op, proc_id, burst, prio
// out_ch    source   kind, out_id, out_burst, out_prio, last
// cfg_ch    sink     index (0 sched_mode, 1 time_quantum), data
//
// one command at a time; all entries live in a single-port-read memory of DEPTH rows
// add: first come and round robin write at the tail, a full queue answers full; sorted modes
// scan from the head for the place and move each later entry one place toward the tail
// run: lists every entry, or answers empty; round robin first passes over every entry
// reset clears the queue count and pointers and restores the config defaults; no clearing pass is needed
// a stalled out_ch holds the walk; in_ch is ready again once the last beat is registered
`default_nettype none

module ready_queue_scheduler (
  input  wire logic clk,
  input  wire logic rst_n,
  rqs_in_if.sink    in_ch,
  rqs_out_if.source out_ch,
  rqs_cfg_if.sink   cfg_ch
);

  rqs_pkg::cmd_t cmd;
  rqs_pkg::sts_t sts;

  rqs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rqs_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

/* dv/ready_queue_scheduler_test.sv */
`timescale 1ns / 1ps

module ready_queue_scheduler_test;
  import rqs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int JOBS_PER_SEGMENT = 30;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last;
  } beat_t;

  typedef struct {
    bit                 to_reg;
    logic [CIDX_W-1:0]  reg_idx;
    logic [CDATA_W-1:0] reg_val;
    logic               op;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    int                 count;
    bit                 typed;
    logic [KIND_W-1:0]  kind;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  rqs_in_if  in_ch();
  rqs_out_if out_ch();
  rqs_cfg_if cfg_ch();

  ready_queue_scheduler DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the ready queue and its registers
  entry_t            sched_ent [DEPTH];
  int                sched_len;
  logic [MODE_W-1:0] cur_mode;
  logic [BURST_W-1:0] cur_quantum;

  beat_t beats_due[$];
  beat_t item_beats[$];
  row_t  plan[$];

  int send_idle_pct;
  int rcv_idle_pct;
  int mismatches;
  int quiet;

  function automatic beat_t make_beat(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] id,
                                      input logic [BURST_W-1:0] burst,
                                      input logic [PRIO_W-1:0] prio,
                                      input logic last);
    beat_t b;
    b.kind  = kind;
    b.id    = id;
    b.burst = burst;
    b.prio  = prio;
    b.last  = last;
    return b;
  endfunction

  function automatic row_t job_row(input logic op, input logic [ID_W-1:0] id,
                                   input logic [BURST_W-1:0] burst,
                                   input logic [PRIO_W-1:0] prio, input int count,
                                   input bit typed, input logic [KIND_W-1:0] kind);
    row_t r;
    r.to_reg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.op      = op;
    r.id      = id;
    r.burst   = burst;
    r.prio    = prio;
    r.count   = count;
    r.typed   = typed;
    r.kind    = kind;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CIDX_W-1:0] idx,
                                   input logic [CDATA_W-1:0] val);
    row_t r;
    r = job_row(OP_ADD, '0, '0, '0, 0, 1'b0, KIND_ADDED);
    r.to_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void add_row(input row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // applies one command to the shadow queue, leaves its beats in item_beats
  task automatic schedule_apply(input logic op, input logic [ID_W-1:0] id,
                                input logic [BURST_W-1:0] burst,
                                input logic [PRIO_W-1:0] prio);
    int pos;
    int keep;
    item_beats.delete();
    if (op == OP_ADD) begin
      if (sched_len >= DEPTH) begin
        item_beats.insert(item_beats.size(), make_beat(KIND_FULL, '0, '0, '0, 1'b1));
      end else begin
        pos = sched_len;
        for (int i = 0; i < sched_len; i++) begin
          if ((cur_mode == MODE_SJF && sched_ent[i].burst > burst) ||
              (cur_mode == MODE_PRIO && sched_ent[i].prio < prio)) begin
            pos = i;
            break;
          end
        end
        for (int i = sched_len; i > pos; i--) sched_ent[i] = sched_ent[i-1];
        sched_ent[pos].id    = id;
        sched_ent[pos].burst = burst;
        sched_ent[pos].prio  = prio;
        sched_len++;
        item_beats.insert(item_beats.size(), make_beat(KIND_ADDED, '0, '0, '0, 1'b1));
      end
    end else begin
      if (cur_mode == MODE_RR) begin
        keep = 0;
        for (int i = 0; i < sched_len; i++) begin
          if (sched_ent[i].burst > cur_quantum) begin
            sched_ent[keep]       = sched_ent[i];
            sched_ent[keep].burst = sched_ent[i].burst - cur_quantum;
            keep++;
          end
        end
        sched_len = keep;
      end
      if (sched_len == 0) begin
        item_beats.insert(item_beats.size(), make_beat(KIND_EMPTY, '0, '0, '0, 1'b1));
      end else begin
        for (int i = 0; i < sched_len; i++) begin
          item_beats.insert(item_beats.size(),
                            make_beat((i == 0) ? KIND_RUNNING : KIND_READY,
                                      sched_ent[i].id, sched_ent[i].burst,
                                      sched_ent[i].prio, i == sched_len - 1));
        end
      end
    end
  endtask

  task automatic send_job(input logic op, input logic [ID_W-1:0] id,
                          input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                          input bit typed, input logic [KIND_W-1:0] kind);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.proc_id <= id;
    in_ch.burst   <= burst;
    in_ch.prio    <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    schedule_apply(op, id, burst, prio);
    if (typed) beats_due.insert(beats_due.size(), make_beat(kind, '0, '0, '0, 1'b1));
    else foreach (item_beats[i]) beats_due.insert(beats_due.size(), item_beats[i]);
  endtask

  task automatic send_random_job();
    logic               op;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    op = ($urandom_range(99) < 25) ? OP_RUN : OP_ADD;
    case ($urandom_range(7))
      0: burst = '0;
      1: burst = '1;
      2, 3: burst = BURST_W'($urandom);
      default: burst = BURST_W'($urandom_range(1, 12));
    endcase
    // narrow priorities make ties common
    prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
    send_job(op, ID_W'($urandom), burst, prio, 1'b0, KIND_ADDED);
  endtask

  // hold keeps valid up for a write that follows at once
  task automatic reg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val,
                           input bit hold);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_MODE) cur_mode = val[MODE_W-1:0];
    else if (idx == CFG_QUANTUM) cur_quantum = val;
    if (!hold) cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk) begin : check_beats
    beat_t got;
    beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = make_beat(out_ch.kind, out_ch.out_id, out_ch.out_burst, out_ch.out_prio,
                      out_ch.last);
      if (beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, %s", $time,
                 $sformatf("got kind=%0d id=%h burst=%h prio=%h last=%b",
                           got.kind, got.id, got.burst, got.prio, got.last));
      end else begin
        want = beats_due.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: beat mismatch, expected kind=%0d id=%h burst=%h prio=%h last=%b, %s",
                   $time, want.kind, want.id, want.burst, want.prio, want.last,
                   $sformatf("got kind=%0d id=%h burst=%h prio=%h last=%b",
                             got.kind, got.id, got.burst, got.prio, got.last));
        end
      end
    end
  end

  // no beat on any channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bit                 hold;
    bit                 prev_reg;
    logic [CDATA_W-1:0] quant_v;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_ADD;
    in_ch.proc_id = '0;
    in_ch.burst   = '0;
    in_ch.prio    = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_MODE;
    cfg_ch.data   = '0;
    cur_mode      = MODE_FCFS;
    cur_quantum   = QUANTUM_RST;
    sched_len     = 0;
    mismatches    = 0;
    quiet         = 0;
    send_idle_pct = 37;
    rcv_idle_pct  = 64;

    // empty after reset, extremes, ties, mode change keeping order
    add_row(job_row(OP_RUN, '0, '0, '0, 1, 1'b1, KIND_EMPTY));
    add_row(job_row(OP_ADD, 16'h0000, 16'h0000, 8'h00, 1, 1'b1, KIND_ADDED));
    add_row(job_row(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF, 1, 1'b1, KIND_ADDED));
    add_row(reg_row(CFG_MODE, CDATA_W'(MODE_PRIO)));
    add_row(job_row(OP_ADD, 16'h0001, 16'h0005, 8'h80, 1, 1'b1, KIND_ADDED));
    add_row(job_row(OP_ADD, 16'h0002, 16'h0007, 8'h80, 1, 1'b1, KIND_ADDED));
    add_row(reg_row(CFG_MODE, CDATA_W'(MODE_SJF)));
    add_row(job_row(OP_ADD, 16'h0003, 16'h0001, 8'h01, 1, 1'b1, KIND_ADDED));
    add_row(job_row(OP_ADD, 16'h0004, 16'hFFFF, 8'h00, 1, 1'b1, KIND_ADDED));
    add_row(job_row(OP_RUN, '0, '0, '0, 1, 1'b0, KIND_ADDED));
    // round robin: zero quantum drops only zero bursts, max quantum drops all
    add_row(reg_row(CFG_MODE, CDATA_W'(MODE_RR)));
    add_row(reg_row(CFG_QUANTUM, 16'h0000));
    add_row(job_row(OP_RUN, '0, '0, '0, 1, 1'b0, KIND_ADDED));
    add_row(reg_row(CFG_QUANTUM, 16'hFFFF));
    add_row(job_row(OP_RUN, '0, '0, '0, 1, 1'b1, KIND_EMPTY));
    add_row(reg_row(CFG_QUANTUM, 16'h0003));
    add_row(job_row(OP_ADD, 16'h0100, 16'h0001, 8'h10, DEPTH, 1'b1, KIND_ADDED));
    add_row(job_row(OP_ADD, 16'h0200, 16'h0040, 8'h20, 1, 1'b1, KIND_FULL));
    add_row(job_row(OP_RUN, '0, '0, '0, 1, 1'b0, KIND_ADDED));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].to_reg) begin
        hold = (r + 1 < plan.size()) && plan[r+1].to_reg;
        if (!prev_reg) drain_results();
        reg_write(plan[r].reg_idx, plan[r].reg_val, hold);
      end else begin
        for (int k = 0; k < plan[r].count; k++)
          send_job(plan[r].op, ID_W'(plan[r].id + k), BURST_W'(plan[r].burst + k),
                   PRIO_W'(plan[r].prio + k), plan[r].typed, plan[r].kind);
      end
      prev_reg = plan[r].to_reg;
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 64 : 0;
      rcv_idle_pct  = (ph == 0) ? 64 : (ph == 1) ? 37 : 0;
      for (int sg = 0; sg < 4; sg++) begin
        drain_results();
        // sometimes empty the queue so that inserts start shallow
        if ($urandom_range(1)) begin
          reg_write(CFG_MODE, CDATA_W'(MODE_RR), 1'b1);
          reg_write(CFG_QUANTUM, '1, 1'b0);
          send_job(OP_RUN, '0, '0, '0, 1'b0, KIND_ADDED);
          drain_results();
        end
        case ($urandom_range(3))
          0: quant_v = '1;
          1: quant_v = CDATA_W'($urandom_range(1, 6));
          2: quant_v = CDATA_W'($urandom_range(1, 40));
          default: quant_v = CDATA_W'($urandom_range(1, 65535));
        endcase
        if (ph == 0) quant_v = 16'd1;
        reg_write(CFG_MODE, CDATA_W'((sg + ph) % 4), 1'b1);
        reg_write(CFG_QUANTUM, quant_v, 1'b0);
        repeat (JOBS_PER_SEGMENT) send_random_job();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
